// ===== rtl/walsh_family_of_ranking_defines.svh =====
// assertion macros used by wfr_ctrl
`ifndef WALSH_FAMILY_OF_RANKING_DEFINES_SVH
`define WALSH_FAMILY_OF_RANKING_DEFINES_SVH
`ifndef ASSERT_OFF
`define WFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WFR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define WFR_ASSERT(lbl, clk, rst, prop, msg)
`define WFR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/wfr_pkg.sv =====
`default_nettype none
package wfr_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int NUM_POINTS  = 8;
  localparam int RANK_W      = 3;
  localparam int K_W         = 4;
  localparam int PICK_W      = 4;
  localparam int WHT_W       = 8;
  localparam int CODE_W      = 7;
  localparam int FAMILY_W    = 128;
  localparam int RANKS_W     = NUM_POINTS * RANK_W;
  localparam int IN_DATA_W   = NUM_POINTS * VALUE_WIDTH;
  localparam int OUT_DATA_W  = RANKS_W + FAMILY_W;

  localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(NUM_POINTS - 1);

  typedef struct packed {
    logic              load;
    logic              rank_step;
    logic [RANK_W-1:0] rank_idx;
    logic              prep;
    logic              walk;
    logic              publish;
  } wfr_cmd_t;

  typedef struct packed {
    logic last;
  } wfr_status_t;

endpackage
`default_nettype wire

// ===== rtl/walsh_family_of_ranking.sv =====
`default_nettype none
// walsh family of a ranking
// input stream: one transaction carries the eight signed values of a 3-bit
// pseudo-boolean function; output stream: one transaction per input with
// the packed ranks and the 128-bit family of reachable walsh structures.
// after acceptance the block ranks the values (one reference value per
// cycle), sets up the walk, then walks the assignments at one walsh
// transform per cycle, and hands the result to the output register once
// the output slot is free. there are n = C(M+1, k) assignments for k
// classes (n = 1 for one or two classes).
// the next input is taken while a result still waits on the output side;
// a stalled receiver only holds the block once a second result is finished.
// synchronous reset empties the output register and returns to idle.
module walsh_family_of_ranking (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // value_0 .. value_7, 16 bits each, value_0 lowest
  input  logic [wfr_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // class_ranks[23:0], family_low[87:24], family_high[151:88]
  output logic [wfr_pkg::OUT_DATA_W-1:0] m_tdata
);
  import wfr_pkg::*;

  wfr_cmd_t    cmd;
  wfr_status_t status;

  wfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wfr_datapath u_datapath (
    .clk     (clk),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .status  (status)
  );

endmodule
`default_nettype wire

// ===== rtl/wfr_ctrl.sv =====
`default_nettype none
`include "walsh_family_of_ranking_defines.svh"
module wfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  wfr_pkg::wfr_status_t status,
  output wfr_pkg::wfr_cmd_t    cmd
);
  import wfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANK,
    S_PREP,
    S_WALK,
    S_HOLD
  } state_t;

  state_t            state;
  logic [RANK_W-1:0] rank_idx;
  logic              out_valid;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && s_tvalid;
    cmd.rank_step = (state == S_RANK);
    cmd.rank_idx  = rank_idx;
    cmd.prep      = (state == S_PREP);
    cmd.walk      = (state == S_WALK);
    // output slot is free or drains in this cycle
    cmd.publish   = (state == S_HOLD) && (!out_valid || m_tready);
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rank_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.publish || (out_valid && !m_tready);
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            rank_idx <= '0;
            state    <= S_RANK;
          end
        end
        S_RANK: begin
          rank_idx <= rank_idx + RANK_W'(1);
          if (rank_idx == RANK_LAST) state <= S_PREP;
        end
        S_PREP: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (status.last) state <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_valid || m_tready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `WFR_ASSERT_NEXT(a_rank_done, clk, rst, (state == S_RANK && rank_idx == RANK_LAST), (state == S_PREP), "rank pass did not end after the last point")
  `WFR_ASSERT_NEXT(a_walk_done, clk, rst, (state == S_WALK && status.last), (state == S_HOLD), "walk did not stop at the last assignment")
  `WFR_ASSERT(a_no_overwrite, clk, rst, (cmd.publish |-> (!out_valid || m_tready)), "result published over a pending transaction")
  `WFR_ASSERT_NEXT(a_publish_shows, clk, rst, cmd.publish, out_valid, "published result not offered")

endmodule
`default_nettype wire

// ===== rtl/wfr_datapath.sv =====
`default_nettype none
module wfr_datapath (
  input  logic                           clk,
  input  logic [wfr_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic [wfr_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wfr_pkg::wfr_cmd_t              cmd,
  output wfr_pkg::wfr_status_t           status
);
  import wfr_pkg::*;

  function automatic logic [K_W-1:0] popcount8(input logic [NUM_POINTS-1:0] v);
    logic [K_W-1:0] n;
    n = '0;
    for (int b = 0; b < NUM_POINTS; b++) n = n + K_W'(v[b]);
    return n;
  endfunction

  // largest value an assignment may use for a given number of classes
  function automatic logic [PICK_W-1:0] top_value(input logic [K_W-1:0] k);
    logic [PICK_W-1:0] m;
    case (k)
      4'd3:    m = 4'd4;
      4'd4:    m = 4'd7;
      4'd5:    m = 4'd10;
      4'd6:    m = 4'd12;
      4'd7:    m = 4'd14;
      4'd8:    m = 4'd15;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  logic signed [VALUE_WIDTH-1:0] vals [NUM_POINTS];
  logic [RANK_W-1:0]             rank [NUM_POINTS];
  logic [RANK_W-1:0]             dense [NUM_POINTS];
  logic [RANK_W-1:0]             dense_next [NUM_POINTS];
  logic [PICK_W-1:0]             pick [NUM_POINTS];
  logic [PICK_W-1:0]             pick_next [NUM_POINTS];
  logic [K_W-1:0]                k_reg;
  logic [K_W-1:0]                k_next;
  logic [PICK_W-1:0]             top_m;
  logic [NUM_POINTS-1:0]         present;
  logic [RANK_W-1:0]             piv;
  logic [PICK_W-1:0]             last_first;
  logic [PICK_W-1:0]             f [NUM_POINTS];
  logic signed [WHT_W-1:0]       a0 [NUM_POINTS];
  logic signed [WHT_W-1:0]       a1 [NUM_POINTS];
  logic signed [WHT_W-1:0]       a2 [NUM_POINTS];
  logic signed [WHT_W-1:0]       a3 [NUM_POINTS];
  logic [CODE_W-1:0]             code;
  logic [FAMILY_W-1:0]           family;
  logic [RANKS_W-1:0]            ranks_packed;
  logic [RANKS_W-1:0]            out_ranks;
  logic [FAMILY_W-1:0]           out_family;

  // distinct ranks and dense class index
  always_comb begin
    present = '0;
    for (int i = 0; i < NUM_POINTS; i++) present[rank[i]] = 1'b1;
    k_next = popcount8(present);
    for (int i = 0; i < NUM_POINTS; i++) begin
      dense_next[i] = RANK_W'(popcount8(present &
                      ((NUM_POINTS'(1) << rank[i]) - NUM_POINTS'(1))));
    end
    ranks_packed = '0;
    for (int i = 0; i < NUM_POINTS; i++) ranks_packed[i*RANK_W +: RANK_W] = rank[i];
  end

  // next strictly increasing assignment: bump the rightmost value with room
  always_comb begin
    logic [PICK_W:0] lim;
    piv = '0;
    for (int t = 0; t < NUM_POINTS; t++) begin
      lim = {1'b0, top_m} + (PICK_W+1)'(1) + (PICK_W+1)'(t) - {1'b0, k_reg};
      if ((K_W'(t) < k_reg) && ({1'b0, pick[t]} < lim)) piv = RANK_W'(t);
    end
    for (int u = 0; u < NUM_POINTS; u++) begin
      pick_next[u] = pick[u];
      if (RANK_W'(u) >= piv) begin
        pick_next[u] = pick[piv] + PICK_W'(1) + PICK_W'(u) - {1'b0, piv};
      end
    end
    last_first = PICK_W'({1'b0, top_m} + (PICK_W+1)'(1) - {1'b0, k_reg});
  end

  assign status.last = (k_reg <= K_W'(2)) || (pick[0] == last_first);

  // 8-point walsh transform of the current function
  always_comb begin
    for (int x = 0; x < NUM_POINTS; x++) begin
      f[x]  = (k_reg <= K_W'(2)) ? {1'b0, rank[x]} : pick[dense[x]];
      a0[x] = $signed({{(WHT_W-PICK_W){1'b0}}, f[x]});
    end
    for (int x = 0; x < NUM_POINTS; x++) begin
      if ((x & 1) == 0) a1[x] = a0[x] + a0[x | 1];
      else              a1[x] = a0[x ^ 1] - a0[x];
    end
    for (int x = 0; x < NUM_POINTS; x++) begin
      if ((x & 2) == 0) a2[x] = a1[x] + a1[x | 2];
      else              a2[x] = a1[x ^ 2] - a1[x];
    end
    for (int x = 0; x < NUM_POINTS; x++) begin
      if ((x & 4) == 0) a3[x] = a2[x] + a2[x | 4];
      else              a3[x] = a2[x ^ 4] - a2[x];
    end
    for (int s = 1; s < NUM_POINTS; s++) code[s-1] = (a3[s] != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        vals[i] <= s_tdata[i*VALUE_WIDTH +: VALUE_WIDTH];
        rank[i] <= '0;
      end
    end
    // one reference point per cycle against all eight values
    if (cmd.rank_step) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        if (vals[cmd.rank_idx] < vals[i]) rank[i] <= rank[i] + RANK_W'(1);
      end
    end
    if (cmd.prep) begin
      k_reg  <= k_next;
      top_m  <= top_value(k_next);
      family <= '0;
      for (int i = 0; i < NUM_POINTS; i++) begin
        dense[i] <= dense_next[i];
        pick[i]  <= PICK_W'(i);
      end
    end
    if (cmd.walk) begin
      family <= family | (FAMILY_W'(1) << code);
      for (int i = 0; i < NUM_POINTS; i++) pick[i] <= pick_next[i];
    end
    if (cmd.publish) begin
      out_ranks  <= ranks_packed;
      out_family <= family;
    end
  end

  assign m_tdata = {out_family, out_ranks};

endmodule
`default_nettype wire
